@@ hw/rtl/ffba_pkg.sv @@
// ---------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit bitmap frame allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam int FRAME_COUNT_DEF = 65536;
  localparam int WORD_BITS_DEF   = 64;

  localparam int CMD_W      = 2;
  localparam int FRAME_ID_W = 16;
  localparam int START_W    = 16;
  localparam int NUM_W      = 17;
  localparam int REG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  // internal frame arithmetic never needs fewer bits than this
  localparam int FRAME_MIN_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FRAME   = 2'd1;

  localparam logic [REG_W-1:0] FIRST_FRAME_RST = 17'd0;
  localparam logic [REG_W-1:0] END_FRAME_RST   = 17'd65536;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic latch_in;
    logic srch_init;
    logic div_start;
    logic srch_load;
    logic rd;
    logic scan;
    logic put_init;
    logic put_load;
    logic put_wr;
    logic pend_fail;
    logic pend_zero;
    logic res_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic clr_done;
    logic div_done;
    logic scan_ok;
    logic scan_fail;
    logic scan_next;
    logic put_empty;
    logic put_last;
  } dp_st_t;

endpackage

`default_nettype wire

@@ hw/rtl/ffba_if.sv @@
// ---------------------------------------------------------------------------
// ffba_if
// Valid/ready channels of the allocator: command, result and register write.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffba_in_if;
  logic                           valid;
  logic                           ready;
  logic [ffba_pkg::CMD_W-1:0]     cmd;
  logic [ffba_pkg::START_W-1:0]   run_start;
  logic [ffba_pkg::NUM_W-1:0]     run_len;

  modport source (output valid, cmd, run_start, run_len, input ready);
  modport sink   (input valid, cmd, run_start, run_len, output ready);
endinterface

interface ffba_out_if;
  logic                              valid;
  logic                              ready;
  logic [ffba_pkg::FRAME_ID_W-1:0]   frame_id;
  logic                              status;

  modport source (output valid, frame_id, status, input ready);
  modport sink   (input valid, frame_id, status, output ready);
endinterface

interface ffba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ffba_pkg::CFG_IDX_W-1:0]   index;
  logic [ffba_pkg::REG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ffba_ram.sv @@
// ---------------------------------------------------------------------------
// ffba_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/ffba_div.sv @@
// ---------------------------------------------------------------------------
// ffba_div
// Word splitter: divides a frame number by the constant word size through a
// reciprocal multiplication, giving word index and bit offset.
// ---------------------------------------------------------------------------
`default_nettype none

module ffba_div #(
  parameter int FW = 18,
  parameter int WB = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [FW-1:0]          dividend_i,
  output      logic                   done_o,
  output      logic [FW-1:0]          quo_o,
  output      logic [$clog2(WB)-1:0]  rem_o
);

  localparam int RW = $clog2(WB);
  localparam int SH = FW + RW;
  localparam int MW = FW + 1;
  localparam int PW = FW + MW;
  // ceil(2^SH / WB) is exact for every dividend below 2^FW
  localparam longint unsigned RECIP_L =
    ((longint'(1) << SH) + longint'(WB) - 1) / longint'(WB);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam logic [FW-1:0] WB_F  = FW'(WB);

  logic          busy_q;
  logic          done_q;
  logic [FW-1:0] dvd_q;
  logic [FW-1:0] quo_q;
  logic [RW-1:0] rem_q;
  logic [PW-1:0] prod;
  logic [FW-1:0] quo_c;
  logic [FW-1:0] back;

  assign prod  = {{(PW - FW){1'b0}}, dividend_i} * {{(PW - MW){1'b0}}, RECIP};
  assign quo_c = FW'(prod >> SH);
  assign back  = quo_q * WB_F;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      quo_q <= quo_c;
    end
    if (busy_q) begin
      rem_q <= RW'(dvd_q - back);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/ffba_dp.sv @@
// ---------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: bitmap memory, config registers, search and run-write
// registers, word splitter and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module ffba_dp #(
  parameter int FRAME_COUNT = ffba_pkg::FRAME_COUNT_DEF,
  parameter int WORD_BITS   = ffba_pkg::WORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ffba_pkg::dp_cmd_t                 cmd_i,
  output      ffba_pkg::dp_st_t                  st_o,
  input  wire logic [ffba_pkg::CMD_W-1:0]        in_cmd_i,
  input  wire logic [ffba_pkg::START_W-1:0]      in_start_i,
  input  wire logic [ffba_pkg::NUM_W-1:0]        in_num_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ffba_pkg::REG_W-1:0]        cfg_data_i,
  output      logic [ffba_pkg::FRAME_ID_W-1:0]   frame_id_o,
  output      logic                              status_o
);

  localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FW = ($clog2(FRAME_COUNT) + 1 > ffba_pkg::FRAME_MIN_W) ?
                      $clog2(FRAME_COUNT) + 1 : ffba_pkg::FRAME_MIN_W;
  localparam int RW = $clog2(WORD_BITS);
  localparam int RUN_W = ffba_pkg::NUM_W + 1;
  localparam int IDW = ffba_pkg::FRAME_ID_W;

  localparam logic [FW-1:0]    FC_F     = FW'(FRAME_COUNT);
  localparam logic [FW-1:0]    WB_F     = FW'(WORD_BITS);
  localparam logic [RW:0]      WB_R     = (RW + 1)'(WORD_BITS);
  localparam logic [RW-1:0]    LAST_BIT = RW'(WORD_BITS - 1);
  localparam logic [RUN_W-1:0] WB_RUN   = RUN_W'(WORD_BITS);
  localparam logic [AW:0]      LAST_WRD = (AW + 1)'(MAP_WORDS - 1);

  // config
  logic [ffba_pkg::REG_W-1:0] first_q, end_q;

  // latched command
  ffba_pkg::cmd_e                    cmd_q;
  logic [ffba_pkg::START_W-1:0]      sf_q;
  logic [ffba_pkg::NUM_W-1:0]        num_q;

  // walk registers of clear, search and run write; only widx_q serves all three
  logic [AW:0]      widx_q, widx_d;
  logic [FW-1:0]    base_q, base_d;
  logic [RW-1:0]    fbit_q, fbit_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [FW-1:0]    cand_q, cand_d;

  // run write
  logic [FW-1:0] s_q, e_q;
  logic          used_q;

  // results
  logic [IDW-1:0] pend_id_q;
  logic           pend_st_q;
  logic [IDW-1:0] frame_id_q;
  logic           status_q;

  // memory
  logic [WORD_BITS-1:0] rdata, wdata, mask;
  logic                 ram_we;

  // splitter
  logic [FW-1:0] div_dvd, div_quo;
  logic [RW-1:0] div_rem;
  logic          div_done;

  // combinational helpers
  logic [FW-1:0]    lim, f, put_src, run_end, run_end_c;
  logic [FW-1:0]    hi_diff;
  logic [RW:0]      lo_off, hi_off;
  logic             ok, over, fast_free, fast_used, fit, aligned_in;

  assign lim     = ({{(FW - ffba_pkg::REG_W){1'b0}}, end_q} > FC_F) ? FC_F :
                   FW'(end_q);
  assign f       = base_q + FW'(fbit_q);
  assign put_src = (cmd_q == ffba_pkg::CMD_ALLOC) ? cand_q : FW'(sf_q);
  assign run_end = put_src + FW'(num_q);
  assign run_end_c = (run_end > FC_F) ? FC_F : run_end;
  assign div_dvd = cmd_i.srch_init ? FW'(first_q) : put_src;

  assign ok         = (run_q == RUN_W'(num_q));
  assign over       = (f >= lim);
  assign aligned_in = (fbit_q == '0) && ((base_q + WB_F) <= lim);
  assign fast_free  = aligned_in && (rdata == '0);
  assign fast_used  = aligned_in && (rdata == '1);
  assign fit        = ((run_q + WB_RUN) >= RUN_W'(num_q));

  always_comb begin
    st_o           = '0;
    st_o.cmd       = cmd_q;
    st_o.clr_done  = (widx_q == LAST_WRD);
    st_o.div_done  = div_done;
    st_o.scan_ok   = ok || (!over && fast_free && fit);
    st_o.scan_fail = !ok && over;
    st_o.scan_next = !ok && !over &&
                     ((fast_free && !fit) || fast_used ||
                      (!fast_free && !fast_used && (fbit_q == LAST_BIT)));
    st_o.put_empty = (num_q == '0) || (s_q >= FC_F);
    st_o.put_last  = ((base_q + WB_F) >= e_q);
  end

  // bits of the current word that lie inside the run
  always_comb begin
    lo_off  = (s_q > base_q) ? (RW + 1)'(s_q - base_q) : '0;
    hi_diff = e_q - base_q;
    hi_off  = (hi_diff >= WB_F) ? WB_R : (RW + 1)'(hi_diff);
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = ((RW + 1)'(i) >= lo_off) && ((RW + 1)'(i) < hi_off);
    end
  end

  assign ram_we = cmd_i.clr_wr || cmd_i.put_wr;
  assign wdata  = cmd_i.clr_wr ? '0 : (used_q ? (rdata | mask) : (rdata & ~mask));

  always_comb begin
    widx_d = widx_q;
    base_d = base_q;
    fbit_d = fbit_q;
    run_d  = run_q;
    cand_d = cand_q;
    if (cmd_i.clr_wr) begin
      widx_d = widx_q + 1'b1;
    end
    if (cmd_i.srch_init) begin
      run_d  = '0;
      cand_d = FW'(first_q);
    end
    if (cmd_i.srch_load) begin
      widx_d = (AW + 1)'(div_quo);
      base_d = FW'(first_q) - FW'(div_rem);
      fbit_d = div_rem;
    end
    if (cmd_i.put_load) begin
      widx_d = (AW + 1)'(div_quo);
      base_d = s_q - FW'(div_rem);
    end
    if (cmd_i.put_wr) begin
      widx_d = widx_q + 1'b1;
      base_d = base_q + WB_F;
    end
    if (cmd_i.scan && !ok && !over) begin
      if (fast_free) begin
        run_d = run_q + WB_RUN;
      end else if (fast_used) begin
        run_d  = '0;
        cand_d = base_q + WB_F;
      end else if (rdata[fbit_q]) begin
        run_d  = '0;
        cand_d = f + 1'b1;
      end else begin
        run_d = run_q + 1'b1;
      end
      if (fast_free || fast_used || (fbit_q == LAST_BIT)) begin
        widx_d = widx_q + 1'b1;
        base_d = base_q + WB_F;
        fbit_d = '0;
      end else begin
        fbit_d = fbit_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= ffba_pkg::FIRST_FRAME_RST;
      end_q   <= ffba_pkg::END_FRAME_RST;
      widx_q  <= '0;
    end else begin
      widx_q <= widx_d;
      if (cfg_valid_i && (cfg_index_i == ffba_pkg::CFG_FIRST_FRAME)) begin
        first_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == ffba_pkg::CFG_END_FRAME)) begin
        end_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    fbit_q <= fbit_d;
    run_q  <= run_d;
    cand_q <= cand_d;
    if (cmd_i.latch_in) begin
      cmd_q <= ffba_pkg::cmd_e'(in_cmd_i);
      sf_q  <= in_start_i;
      num_q <= in_num_i;
    end
    if (cmd_i.put_init) begin
      s_q       <= put_src;
      e_q       <= run_end_c;
      used_q    <= (cmd_q != ffba_pkg::CMD_FREE);
      pend_id_q <= (cmd_q == ffba_pkg::CMD_ALLOC) ? IDW'(cand_q) : '0;
      pend_st_q <= 1'b0;
    end
    if (cmd_i.pend_fail) begin
      pend_id_q <= '0;
      pend_st_q <= 1'b1;
    end
    if (cmd_i.pend_zero) begin
      pend_id_q <= '0;
      pend_st_q <= 1'b0;
    end
    if (cmd_i.res_load) begin
      frame_id_q <= pend_id_q;
      status_q   <= pend_st_q;
    end
  end

  assign frame_id_o = frame_id_q;
  assign status_o   = status_q;

  ffba_div #(
    .FW (FW),
    .WB (WORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  ffba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.rd),
    .addr_i  (widx_q[AW-1:0]),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  a_wr_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (widx_q <= LAST_WRD))
    else $error("bitmap write beyond the last word");

  a_put_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put_wr |-> ((num_q != '0) && (s_q < FC_F)))
    else $error("run write issued for an empty run");

endmodule

`default_nettype wire

@@ hw/rtl/ffba_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffba_ctrl
// Allocator sequencer: clearing pass, command dispatch, word-by-word search,
// run write and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      ffba_pkg::dp_cmd_t  cmd_o,
  input  wire ffba_pkg::dp_st_t   st_i
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DISP  = 10'b0000000100,
    S_ADIV  = 10'b0000001000,
    S_ARD   = 10'b0000010000,
    S_ASCAN = 10'b0000100000,
    S_PDIV  = 10'b0001000000,
    S_PRD   = 10'b0010000000,
    S_PWR   = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (st_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st_i.cmd)
          ffba_pkg::CMD_ALLOC: begin
            cmd_o.srch_init = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = S_ADIV;
          end
          ffba_pkg::CMD_FREE, ffba_pkg::CMD_MARK: begin
            cmd_o.put_init  = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = S_PDIV;
          end
          default: begin
            cmd_o.pend_zero = 1'b1;
            state_d         = S_RESP;
          end
        endcase
      end
      S_ADIV: begin
        if (st_i.div_done) begin
          cmd_o.srch_load = 1'b1;
          state_d         = S_ARD;
        end
      end
      S_ARD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_ASCAN;
      end
      S_ASCAN: begin
        cmd_o.scan = 1'b1;
        priority if (st_i.scan_ok) begin
          cmd_o.put_init  = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = S_PDIV;
        end else if (st_i.scan_fail) begin
          cmd_o.pend_fail = 1'b1;
          state_d         = S_RESP;
        end else if (st_i.scan_next) begin
          state_d = S_ARD;
        end else begin
          state_d = S_ASCAN;
        end
      end
      S_PDIV: begin
        if (st_i.div_done) begin
          cmd_o.put_load = 1'b1;
          state_d        = st_i.put_empty ? S_RESP : S_PRD;
        end
      end
      S_PRD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_PWR;
      end
      S_PWR: begin
        cmd_o.put_wr = 1'b1;
        state_d      = st_i.put_last ? S_RESP : S_PRD;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_rd_then_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> ((state_q == S_ASCAN) || (state_q == S_PWR)))
    else $error("bitmap read not followed by a scan or a write");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESP) && out_valid_q && !out_ready_i) |=> (state_q == S_RESP))
    else $error("result overwritten while the previous one is pending");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !cmd_o.latch_in || $past(st_i.clr_done))
    else $error("command taken during the clearing pass");

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_bitmap_frame_allocator.sv @@
// ---------------------------------------------------------------------------
// first_fit_bitmap_frame_allocator
// Bitmap page-frame allocator: first-fit run allocation, free and mark.
// ---------------------------------------------------------------------------
//  port       | dir  | transaction
//  item_i     | sink | one command: cmd, run_start, run_len
//  result_o   | src  | one per command: frame_id, status
//  cfg_i      | sink | register write: index 0 first_frame, 1 end_frame
//
//  reset: a clearing pass zeroes the bitmap, one word per cycle (MAP_WORDS
//  words, 1024 by default); commands wait for it, register writes do not
//  allocate: split first_frame, read each word, pass free or used aligned words
//  whole, scan mixed or partial words by bit, split the run start, read and write
//  each word marked; free and mark: split the start, read and write each word;
//  every command: accept, dispatch, hand-off; a held result stalls the next one
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_bitmap_frame_allocator #(
  parameter int FRAME_COUNT = ffba_pkg::FRAME_COUNT_DEF,
  parameter int WORD_BITS   = ffba_pkg::WORD_BITS_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  ffba_in_if.sink   item_i,
  ffba_out_if.source result_o,
  ffba_cfg_if.sink  cfg_i
);

  ffba_pkg::dp_cmd_t dp_cmd;
  ffba_pkg::dp_st_t  dp_st;

  assign cfg_i.ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (dp_cmd),
    .st_i        (dp_st)
  );

  ffba_dp #(
    .FRAME_COUNT (FRAME_COUNT),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .st_o        (dp_st),
    .in_cmd_i    (item_i.cmd),
    .in_start_i  (item_i.run_start),
    .in_num_i    (item_i.run_len),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .frame_id_o  (result_o.frame_id),
    .status_o    (result_o.status)
  );

endmodule

`default_nettype wire

@@ dv/ffba_tb_if.sv @@
// ---------------------------------------------------------------------------
// ffba_tb_if
// The allocator's channel interfaces come from the rtl file ffba_if.sv;
// this file only holds the type of an expected result used by the testbench.
// ---------------------------------------------------------------------------
`default_nettype none

package ffba_tb_pkg;
  typedef struct packed {
    logic [ffba_pkg::FRAME_ID_W-1:0] frame_id;
    logic                            status;
  } alloc_result_t;
endpackage

`default_nettype wire

@@ dv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Testbench of the first-fit bitmap frame allocator: directed commands at the
// field and register extremes, then random command mixes inside small search
// windows, each result checked against a bitmap predictor kept in the bench.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES     = 65536;
  localparam int CYCLE_STOP = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ffba_in_if  in_if();
  ffba_out_if out_if();
  ffba_cfg_if cfg_if();

  first_fit_bitmap_frame_allocator dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_if),
    .result_o (out_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic                           frame_used [FRAMES];
  logic [ffba_pkg::REG_W-1:0]     search_first;
  logic [ffba_pkg::REG_W-1:0]     search_end;
  ffba_tb_pkg::alloc_result_t     pending_results[$];

  int  err_cnt  = 0;
  int  cyc_cnt  = 0;
  bit  no_idle  = 1'b0;
  int  rx_gap   = 0;
  int  hold_cnt = 0;

  function automatic void set_run(int start, int count, logic used);
    for (int i = 0; i < count; i++) begin
      if (start + i >= FRAMES) break;
      frame_used[start + i] = used;
    end
  endfunction

  function automatic ffba_tb_pkg::alloc_result_t apply_command(ffba_pkg::cmd_e cmd,
                                                               int sf, int num);
    ffba_tb_pkg::alloc_result_t r;
    int lim;
    int cand;
    int run;
    int f;
    r = '0;
    case (cmd)
      ffba_pkg::CMD_ALLOC: begin
        lim  = (search_end > FRAMES) ? FRAMES : int'(search_end);
        cand = search_first;
        run  = 0;
        f    = search_first;
        forever begin
          if (run == num) begin
            set_run(cand, num, 1'b1);
            r.frame_id = cand[15:0];
            break;
          end
          if (f >= lim) begin
            r.status = 1'b1;
            break;
          end
          if (f >= FRAMES || frame_used[f]) begin
            run  = 0;
            cand = f + 1;
          end else begin
            run++;
          end
          f++;
        end
      end
      ffba_pkg::CMD_FREE: set_run(sf, num, 1'b0);
      ffba_pkg::CMD_MARK: set_run(sf, num, 1'b1);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_cmd(ffba_pkg::cmd_e cmd, int sf, int num);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
    @(negedge clk_i);
    in_if.valid     = 1'b1;
    in_if.cmd       = cmd;
    in_if.run_start = sf[15:0];
    in_if.run_len   = num[16:0];
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(apply_command(cmd, sf & 16'hffff, num & 17'h1ffff));
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ffba_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value[16:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == ffba_pkg::CFG_FIRST_FRAME) search_first = value[16:0];
    else if (idx == ffba_pkg::CFG_END_FRAME) search_end = value[16:0];
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_window(int first, int last);
    end_burst();
    write_reg(ffba_pkg::CFG_FIRST_FRAME, first);
    write_reg(ffba_pkg::CFG_END_FRAME, last);
  endtask

  // receiver side
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    ffba_tb_pkg::alloc_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      rx_gap = no_idle ? 0 : $urandom_range(0, 12);
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.frame_id !== exp_r.frame_id) begin
          $error("frame_id expected %0d actual %0d", exp_r.frame_id, out_if.frame_id);
          err_cnt++;
        end
        if (out_if.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_if.status);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_STOP) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_commands();
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 0);
    send_cmd(ffba_pkg::CMD_ALLOC, 16'hffff, FRAMES);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 1);
    send_cmd(ffba_pkg::CMD_FREE, 0, FRAMES);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 1);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 3);
    send_cmd(ffba_pkg::CMD_MARK, 10, 5);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 8);
    send_cmd(ffba_pkg::CMD_FREE, 2, 1);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 1);
    send_cmd(ffba_pkg::CMD_NOP, 16'hffff, 17'h1ffff);
    send_cmd(ffba_pkg::CMD_FREE, 0, 0);
    send_cmd(ffba_pkg::CMD_MARK, 20, 0);
    send_cmd(ffba_pkg::CMD_MARK, 65535, 1);
    send_cmd(ffba_pkg::CMD_FREE, 65535, 1);
    // runs crossing the top of the bitmap are clipped
    send_cmd(ffba_pkg::CMD_MARK, 65530, FRAMES);
    send_cmd(ffba_pkg::CMD_FREE, 65530, FRAMES);
    end_burst();
  endtask

  task automatic test_register_extremes();
    set_window(FRAMES, FRAMES);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 0);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 1);
    set_window(0, 0);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 1);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 0);
    set_window(100, 50);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 0);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 2);
    set_window(65530, FRAMES);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 6);
    send_cmd(ffba_pkg::CMD_ALLOC, 0, 1);
    send_cmd(ffba_pkg::CMD_FREE, 65530, 6);
    set_window(0, FRAMES);
  endtask

  task automatic random_mix(int first, int span, int count);
    int sel;
    int sf;
    int num;
    ffba_pkg::cmd_e cmd;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        // noise: any command, any run start, run length up to FRAMES
        cmd = ffba_pkg::cmd_e'($urandom_range(0, 3));
        sf  = $urandom_range(0, 65535);
        num = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FRAMES) : $urandom_range(0, 40);
      end else if (sel < 55) begin
        cmd = ffba_pkg::CMD_ALLOC;
        sf  = $urandom_range(0, 65535);
        num = ($urandom_range(0, 9) == 0) ? $urandom_range(0, span + 4) : $urandom_range(0, 24);
      end else if (sel < 85) begin
        cmd = ffba_pkg::CMD_FREE;
        sf  = first + $urandom_range(0, span);
        num = $urandom_range(0, 48);
      end else begin
        cmd = ffba_pkg::CMD_MARK;
        sf  = first + $urandom_range(0, span);
        num = $urandom_range(0, 16);
      end
      if (sf > 65535) sf = 65535;
      send_cmd(cmd, sf, num);
    end
  endtask

  task automatic test_random_windows();
    int first;
    int span;
    for (int p = 0; p < 8; p++) begin
      no_idle = (p % 3 == 2);
      span  = $urandom_range(16, 400);
      case (p)
        0: first = 0;
        1: first = FRAMES - span;
        default: first = $urandom_range(0, FRAMES - 500);
      endcase
      set_window(first, first + span);
      random_mix(first, span, 50);
    end
    no_idle = 1'b0;
    end_burst();
  endtask

  task automatic test_backpressure();
    set_window(300, 700);
    no_idle  = 1'b1;
    hold_cnt = 400;
    random_mix(300, 400, 12);
    no_idle = 1'b0;
    end_burst();
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.cmd       = ffba_pkg::CMD_NOP;
    in_if.run_start = '0;
    in_if.run_len   = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = ffba_pkg::CFG_FIRST_FRAME;
    cfg_if.data     = '0;
    search_first    = ffba_pkg::FIRST_FRAME_RST;
    search_end      = ffba_pkg::END_FRAME_RST;
    foreach (frame_used[i]) frame_used[i] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_commands();
    test_register_extremes();
    test_random_windows();
    test_backpressure();

    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
